// ===== rtl/periodic_task_slot_scheduler_defines.svh =====
// Assertion macros of the scheduler checker.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PTSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PTSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptss_pkg.sv =====
// Shared widths, operation codes and controller/datapath types of the scheduler.
package ptss_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 31;
  localparam int PER_W     = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUERY      = 3'd0,
    FUNC_SETUP      = 3'd1,
    FUNC_ELAPSE     = 3'd2,
    FUNC_SET_PERIOD = 3'd3,
    FUNC_RESCHEDULE = 3'd4
  } func_t;

  typedef struct packed {
    logic load;      // latch the incoming item
    logic rd_per;    // read the period of the addressed slot
    logic update;    // apply the operation to the addressed slot
    logic sweep;     // walk all slots: elapse and min/due search
    logic out_load;  // move the result into the output register
  } ptss_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic out_busy;
  } ptss_sts_t;

endpackage

// ===== rtl/ptss_if.sv =====
// Request and result channel interfaces of the scheduler.
interface ptss_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptss_pkg::FUNC_W-1:0]   func;
  logic [ptss_pkg::SLOT_W-1:0]   slot;
  logic [ptss_pkg::TIME_W-1:0]   time_value;
  logic                          enable;

  modport source (output valid, func, slot, time_value, enable, input ready);
  modport sink   (input valid, func, slot, time_value, enable, output ready);
endinterface

interface ptss_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               due_found;
  logic [ptss_pkg::SLOT_W-1:0]        due_slot;
  logic [ptss_pkg::TIME_W-1:0]        next_sleep;
  logic signed [ptss_pkg::PER_W-1:0]  slot_period;
  logic                               bad_param;

  modport source (output valid, due_found, due_slot, next_sleep, slot_period, bad_param,
                  input ready);
  modport sink   (input valid, due_found, due_slot, next_sleep, slot_period, bad_param,
                  output ready);
endinterface

// ===== rtl/ptss_ctrl.sv =====
// Sequencing state machine of the scheduler.
module ptss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  ptss_pkg::ptss_sts_t sts,
  output ptss_pkg::ptss_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_PER,
    ST_UPDATE,
    ST_SWEEP,
    ST_RD_OUT,
    ST_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:   if (valid) state <= ST_RD_PER;
        ST_RD_PER: state <= ST_UPDATE;
        ST_UPDATE: state <= ST_SWEEP;
        ST_SWEEP:  if (sts.sweep_done) state <= ST_RD_OUT;
        ST_RD_OUT: state <= ST_OUT;
        ST_OUT:    if (!sts.out_busy) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    ready        = (state == ST_IDLE);
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && valid;
    cmd.rd_per   = (state == ST_RD_PER) || (state == ST_RD_OUT);
    cmd.update   = (state == ST_UPDATE);
    cmd.sweep    = (state == ST_SWEEP);
    cmd.out_load = (state == ST_OUT) && !sts.out_busy;
  end

endmodule

// ===== rtl/ptss_dp.sv =====
// Slot table, sweep unit and result register of the scheduler.
module ptss_dp #(
  parameter int SLOTS = ptss_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ptss_pkg::ptss_cmd_t                cmd,
  output ptss_pkg::ptss_sts_t                sts,
  input  logic [ptss_pkg::FUNC_W-1:0]        func,
  input  logic [ptss_pkg::SLOT_W-1:0]        slot,
  input  logic [ptss_pkg::TIME_W-1:0]        time_value,
  input  logic                               enable,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic                               due_found,
  output logic [ptss_pkg::SLOT_W-1:0]        due_slot,
  output logic [ptss_pkg::TIME_W-1:0]        next_sleep,
  output logic signed [ptss_pkg::PER_W-1:0]  slot_period,
  output logic                               bad_param
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int SLW = ptss_pkg::SLOT_W;
  localparam int TW  = ptss_pkg::TIME_W;

  // latched item
  logic [ptss_pkg::FUNC_W-1:0] func_q;
  logic [SLW-1:0]              slot_q;
  logic [TW-1:0]               tv_q;
  logic                        en_q;

  // slot table
  logic [SLOTS-1:0] active;
  logic [TW-1:0]    per_mem [SLOTS];
  logic [TW-1:0]    rem_mem [SLOTS];
  logic [TW-1:0]    per_rd;
  logic [TW-1:0]    rem_rd;

  // sweep
  logic [CW-1:0]  rd_idx;
  logic           p_vld;
  logic [SW-1:0]  p_idx;
  logic           found;
  logic [SLW-1:0] due;
  logic [TW-1:0]  sleep;
  logic           bad;

  logic           slot_ok;
  logic [SW-1:0]  saddr;
  logic           live;
  logic           is_el;
  logic           act_p;
  logic [TW-1:0]  rem_new;
  logic           bad_c;
  logic           per_we;
  logic           rem_we;
  logic [SW-1:0]  rem_wa;
  logic [TW-1:0]  rem_wd;

  assign slot_ok = ({1'b0, slot_q} < (SLW + 1)'(SLOTS));
  assign saddr   = slot_q[SW-1:0];
  assign live    = slot_ok && active[saddr];
  assign is_el   = (func_q == ptss_pkg::FUNC_ELAPSE);
  assign act_p   = active[p_idx];

  // saturating elapse on the entry under the sweep
  always_comb begin
    rem_new = rem_rd;
    if (is_el && act_p) begin
      rem_new = (rem_rd < tv_q) ? '0 : rem_rd - tv_q;
    end
  end

  always_comb begin
    case (func_q)
      ptss_pkg::FUNC_SETUP:      bad_c = !slot_ok;
      ptss_pkg::FUNC_SET_PERIOD: bad_c = !live;
      ptss_pkg::FUNC_RESCHEDULE: bad_c = !live;
      default:                   bad_c = 1'b0;
    endcase
  end

  always_comb begin
    per_we = 1'b0;
    if (cmd.update) begin
      per_we = ((func_q == ptss_pkg::FUNC_SETUP) && slot_ok) ||
               ((func_q == ptss_pkg::FUNC_SET_PERIOD) && live);
    end
  end

  // one write port on the remaining-time memory: update or sweep write-back
  always_comb begin
    rem_we = 1'b0;
    rem_wa = p_idx;
    rem_wd = rem_new;
    if (cmd.update) begin
      rem_wa = saddr;
      case (func_q)
        ptss_pkg::FUNC_SETUP: begin
          rem_we = slot_ok;
          rem_wd = '0;
        end
        ptss_pkg::FUNC_SET_PERIOD: begin
          rem_we = live;
          rem_wd = tv_q;
        end
        ptss_pkg::FUNC_RESCHEDULE: begin
          rem_we = live;
          rem_wd = per_rd;
        end
        default: rem_we = 1'b0;
      endcase
    end else if (cmd.sweep && p_vld && is_el && act_p) begin
      rem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (per_we) per_mem[saddr] <= tv_q;
    if (cmd.rd_per) per_rd <= per_mem[saddr];
  end

  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (cmd.sweep && (rd_idx != CW'(SLOTS))) rem_rd <= rem_mem[rd_idx[SW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      rd_idx    <= '0;
      p_vld     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.update && (func_q == ptss_pkg::FUNC_SETUP) && slot_ok) begin
        active[saddr] <= en_q;
      end
      if (cmd.update) begin
        rd_idx <= '0;
        p_vld  <= 1'b0;
      end else if (cmd.sweep) begin
        if (rd_idx != CW'(SLOTS)) begin
          p_vld  <= 1'b1;
          rd_idx <= rd_idx + 1'b1;
        end else begin
          p_vld <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      slot_q <= slot;
      tv_q   <= time_value;
      en_q   <= enable;
    end
    if (cmd.update) begin
      found <= 1'b0;
      due   <= '0;
      sleep <= '1;
      bad   <= bad_c;
    end else if (cmd.sweep) begin
      if (rd_idx != CW'(SLOTS)) p_idx <= rd_idx[SW-1:0];
      if (p_vld && act_p) begin
        if (!found && (rem_new == '0)) begin
          found <= 1'b1;
          due   <= SLW'(p_idx);
        end
        if (rem_new < sleep) sleep <= rem_new;
      end
    end
    if (cmd.out_load) begin
      due_found   <= found;
      due_slot    <= due;
      next_sleep  <= sleep;
      slot_period <= live ? $signed({1'b0, per_rd}) : '1;
      bad_param   <= bad;
    end
  end

  assign sts.sweep_done = cmd.sweep && p_vld && (p_idx == SW'(SLOTS - 1));
  assign sts.out_busy   = rsp_valid && !rsp_ready;

endmodule

// ===== rtl/periodic_task_slot_scheduler.sv =====
// Top level of the periodic task slot scheduler.
//
//   channel  modport        moves                                   per item
//   req      ptss_req_if    func, slot, time_value, enable          one operation
//   rsp      ptss_rsp_if    due_found, due_slot, next_sleep,        one result
//                           slot_period, bad_param
//
// One item at a time: no new item is taken until the result register holds the
// last one. The sweep over the remaining-time memory reads one slot per cycle
// through its single registered read port; the period read and update come
// before it, the result read after it.
// rst is synchronous, active high: all slots go inactive, the table contents
// are left as they are (the contents of an inactive slot are never used).
// A result waits in the output register while rsp.ready is low; req.ready
// returns high once the result register has taken the item.
module periodic_task_slot_scheduler #(
  parameter int SLOTS = ptss_pkg::SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  ptss_req_if.sink   req,
  ptss_rsp_if.source rsp
);

  ptss_pkg::ptss_cmd_t cmd;
  ptss_pkg::ptss_sts_t sts;

  // sequencer: idle, period read, update, sweep, result read, result hand-off
  ptss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (req.valid),
    .ready (req.ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  // table, saturating elapse, lowest-due and minimum search, result register
  ptss_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (req.func),
    .slot        (req.slot),
    .time_value  (req.time_value),
    .enable      (req.enable),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .due_found   (rsp.due_found),
    .due_slot    (rsp.due_slot),
    .next_sleep  (rsp.next_sleep),
    .slot_period (rsp.slot_period),
    .bad_param   (rsp.bad_param)
  );

endmodule

// ===== rtl/ptss_checker.sv =====
// Port-level assertions of the scheduler and their bind.
`include "periodic_task_slot_scheduler_defines.svh"

module ptss_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        due_found,
  input logic [ptss_pkg::SLOT_W-1:0] due_slot,
  input logic [ptss_pkg::TIME_W-1:0] next_sleep
);

  // a held result stays offered
  `PTSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

  // one item at a time: busy right after an accept
  `PTSS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "second item taken while busy")

  // a due slot has zero remaining time, so the minimum is zero
  `PTSS_ASSERT_NOW(a_due_sleep, rsp_valid && due_found, next_sleep == '0, "due slot but nonzero sleep")

  // no due slot reports slot zero
  `PTSS_ASSERT_NOW(a_no_due_slot, rsp_valid && !due_found, due_slot == '0, "due_slot set without due slot")

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .due_found  (rsp.due_found),
  .due_slot   (rsp.due_slot),
  .next_sleep (rsp.next_sleep)
);
